// ===== design/ptd_pkg.sv =====
// Shared types and constants for the profiler trace event decoder.
`timescale 1ns / 1ps

package ptd_pkg;

  // Parser phase: which part of an event the next byte belongs to.
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_TP_SEC   = 4'd1,
    PH_TP_THIRD = 4'd2,
    PH_TP_REST  = 4'd3,
    PH_HP       = 4'd4,
    PH_DAT_HDR  = 4'd5,
    PH_DAT_PAY  = 4'd6,
    PH_DAT_STR  = 4'd7,
    PH_REG_HDR  = 4'd8,
    PH_REG_NAME = 4'd9
  } phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_TP  = 2'd0;
  localparam logic [1:0] KIND_HP  = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;
  localparam logic [1:0] KIND_ERR = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_TP_CUT  = 3'd1;
  localparam logic [2:0] ERR_HP_CUT  = 3'd2;
  localparam logic [2:0] ERR_DATA    = 3'd3;
  localparam logic [2:0] ERR_REG_CUT = 3'd4;
  localparam logic [2:0] ERR_UNKNOWN = 3'd5;

  // Lead bytes.
  localparam logic [3:0] LEAD_DATA_HI = 4'hA;
  localparam logic [7:0] LEAD_HP      = 8'hFD;
  localparam logic [7:0] LEAD_REG     = 8'hFE;
  localparam logic [7:0] LEAD_PAD     = 8'hFF;

  // Data payload types (low nibble of the data lead byte).
  localparam logic [3:0] DT_B1   = 4'h1;
  localparam logic [3:0] DT_B2   = 4'h2;
  localparam logic [3:0] DT_B4A  = 4'h3;
  localparam logic [3:0] DT_B8A  = 4'h4;
  localparam logic [3:0] DT_B4B  = 4'h5;
  localparam logic [3:0] DT_B8B  = 4'h6;
  localparam logic [3:0] DT_STR  = 4'hF;

  // Id register type that carries a level.
  localparam logic [7:0] ID_TYPE_LEVEL = 8'h01;

  // Level reported for an id with no registered level (-127).
  localparam logic signed [7:0] LEVEL_NONE = 8'sh81;

endpackage

// ===== design/profiler_trace_event_decoder.sv =====
// Top level of the profiler trace event decoder: byte parser, level table, result register.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall): one trace byte per transfer, or a
//   transfer with in_stream_end high that marks the end of the stream.
//   Result channel (out_valid / out_stall): at most one result per input
//   transfer: a timepoint, a high-precision stamp, a clean end, or an error.
//   A result is visible on the outputs in the cycle after the transfer of
//   the byte that completes the event. Throughput: one byte per cycle while
//   in_stall is low, set by the combinational parse step and the one read
//   port of the level table; the result register lets the next byte in
//   while a result waits. When the receiver stalls a waiting result,
//   in_stall goes high and the parser holds until that result is taken.
//   Reset (synchronous, rst_n low) returns the parser to idle, clears the
//   halt flag, then runs a clearing pass over the level table that writes
//   one entry per cycle, with in_stall held high until the pass ends.
//   After any error the block keeps taking bytes but gives no results until
//   the next reset. A clean end while idle keeps the table, so a new stream
//   may follow.
module profiler_trace_event_decoder #(
  parameter int ID_COUNT = 16384
) (
  input  logic               clk,
  input  logic               rst_n,
  // byte input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte_value,
  input  logic               in_stream_end,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_event_kind,
  output logic [55:0]        out_event_value,
  output logic [13:0]        out_point_id,
  output logic signed [7:0]  out_point_level,
  output logic               out_is_registered,
  output logic [2:0]         out_error_code
);

  localparam int IDW = $clog2(ID_COUNT);
  localparam logic [IDW-1:0] CLR_LAST = IDW'(ID_COUNT - 1);

  // ---------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------
  ptd_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;         // header / stamp / delta bytes left
  logic [55:0] asm_r, asm_nxt;         // assembly shift register
  logic [13:0] pid_r, pid_nxt;         // pending id
  logic [7:0]  plvl_r, plvl_nxt;       // pending level
  logic [7:0]  ptype_r, ptype_nxt;     // pending id register type
  logic [3:0]  pay_r, pay_nxt;         // data payload bytes left
  logic        halted_r, halted_nxt;

  // Level table clearing pass
  logic           clr_active_r;
  logic [IDW-1:0] clr_cnt_r;

  // Level table: {valid mark, level}
  logic [8:0]     mem [ID_COUNT];
  logic           mem_we, mem_re;
  logic [IDW-1:0] mem_waddr, mem_raddr;
  logic [8:0]     mem_wdata;
  logic [8:0]     mem_q_r;

  // Result register
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [55:0] out_value_r;
  logic [13:0] out_id_r;
  logic [2:0]  out_err_r;
  logic        out_inrange_r;

  // Parse step outputs
  logic        in_accept;
  logic        res_gen, res_load, res_tp;
  logic [1:0]  res_kind;
  logic [55:0] res_value;
  logic [13:0] res_id;
  logic [2:0]  res_err;
  logic        res_inrange;
  logic        reg_wr;
  logic        pid_inrange;
  logic [55:0] shift_val;
  logic [3:0]  cnt_dec, pay_dec;

  assign in_stall  = clr_active_r | (out_valid_r & out_stall);
  assign in_accept = in_valid & ~in_stall;
  assign res_load  = in_accept & res_gen;

  assign shift_val   = {asm_r[47:0], in_byte_value};
  assign cnt_dec     = cnt_r - 4'd1;
  assign pay_dec     = pay_r - 4'd1;
  assign pid_inrange = (32'(pid_r) < ID_COUNT);
  assign res_inrange = (32'(res_id) < ID_COUNT);

  // ---------------------------------------------------------------------
  // Parse step: next state and result for the byte at the input
  // ---------------------------------------------------------------------
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    asm_nxt    = asm_r;
    pid_nxt    = pid_r;
    plvl_nxt   = plvl_r;
    ptype_nxt  = ptype_r;
    pay_nxt    = pay_r;
    halted_nxt = halted_r;
    res_gen    = 1'b0;
    res_tp     = 1'b0;
    res_kind   = ptd_pkg::KIND_TP;
    res_value  = '0;
    res_id     = '0;
    res_err    = ptd_pkg::ERR_NONE;
    reg_wr     = 1'b0;

    if (in_accept && !halted_r) begin
      if (in_stream_end) begin
        res_gen   = 1'b1;
        phase_nxt = ptd_pkg::PH_IDLE;
        if (phase_r == ptd_pkg::PH_IDLE) begin
          res_kind = ptd_pkg::KIND_END;
        end else begin
          res_kind   = ptd_pkg::KIND_ERR;
          halted_nxt = 1'b1;
          case (phase_r)
            ptd_pkg::PH_TP_SEC, ptd_pkg::PH_TP_THIRD, ptd_pkg::PH_TP_REST: begin
              res_err = ptd_pkg::ERR_TP_CUT;
            end
            ptd_pkg::PH_HP: begin
              res_err = ptd_pkg::ERR_HP_CUT;
            end
            ptd_pkg::PH_DAT_HDR, ptd_pkg::PH_DAT_PAY, ptd_pkg::PH_DAT_STR: begin
              res_err = ptd_pkg::ERR_DATA;
            end
            default: begin
              res_err = ptd_pkg::ERR_REG_CUT;
            end
          endcase
        end
      end else begin
        case (phase_r)
          ptd_pkg::PH_IDLE: begin
            if (!in_byte_value[7]) begin
              asm_nxt   = {49'd0, in_byte_value[6:0]};
              phase_nxt = ptd_pkg::PH_TP_SEC;
            end else if (in_byte_value[7:4] == ptd_pkg::LEAD_DATA_HI) begin
              asm_nxt   = {52'd0, in_byte_value[3:0]};
              cnt_nxt   = 4'd2;
              phase_nxt = ptd_pkg::PH_DAT_HDR;
            end else if (in_byte_value == ptd_pkg::LEAD_HP) begin
              asm_nxt   = '0;
              cnt_nxt   = 4'd7;
              phase_nxt = ptd_pkg::PH_HP;
            end else if (in_byte_value == ptd_pkg::LEAD_REG) begin
              asm_nxt   = '0;
              cnt_nxt   = 4'd4;
              phase_nxt = ptd_pkg::PH_REG_HDR;
            end else if (in_byte_value != ptd_pkg::LEAD_PAD) begin
              res_gen    = 1'b1;
              res_kind   = ptd_pkg::KIND_ERR;
              res_err    = ptd_pkg::ERR_UNKNOWN;
              res_value  = {48'd0, in_byte_value};
              halted_nxt = 1'b1;
            end
          end
          ptd_pkg::PH_TP_SEC: begin
            if (!in_byte_value[7]) begin
              // short timepoint: 7-bit id, 7-bit delta
              res_gen   = 1'b1;
              res_tp    = 1'b1;
              res_id    = {7'd0, asm_r[6:0]};
              res_value = {48'd0, in_byte_value};
              phase_nxt = ptd_pkg::PH_IDLE;
            end else begin
              pid_nxt   = {asm_r[6:0], in_byte_value[6:0]};
              phase_nxt = ptd_pkg::PH_TP_THIRD;
            end
          end
          ptd_pkg::PH_TP_THIRD: begin
            if (!in_byte_value[7]) begin
              asm_nxt = {48'd0, in_byte_value};
              cnt_nxt = 4'd1;
            end else begin
              asm_nxt = {49'd0, in_byte_value[6:0]};
              cnt_nxt = 4'd5;
            end
            phase_nxt = ptd_pkg::PH_TP_REST;
          end
          ptd_pkg::PH_TP_REST: begin
            asm_nxt = shift_val;
            cnt_nxt = cnt_dec;
            if (cnt_dec == 4'd0) begin
              res_gen   = 1'b1;
              res_tp    = 1'b1;
              res_id    = pid_r;
              res_value = shift_val;
              phase_nxt = ptd_pkg::PH_IDLE;
            end
          end
          ptd_pkg::PH_HP: begin
            asm_nxt = shift_val;
            cnt_nxt = cnt_dec;
            if (cnt_dec == 4'd0) begin
              res_gen   = 1'b1;
              res_kind  = ptd_pkg::KIND_HP;
              res_value = shift_val;
              phase_nxt = ptd_pkg::PH_IDLE;
            end
          end
          ptd_pkg::PH_DAT_HDR: begin
            cnt_nxt = cnt_dec;
            if (cnt_dec == 4'd0) begin
              phase_nxt = ptd_pkg::PH_DAT_PAY;
              case (asm_r[3:0])
                ptd_pkg::DT_B1: begin
                  pay_nxt = 4'd1;
                end
                ptd_pkg::DT_B2: begin
                  pay_nxt = 4'd2;
                end
                ptd_pkg::DT_B4A, ptd_pkg::DT_B4B: begin
                  pay_nxt = 4'd4;
                end
                ptd_pkg::DT_B8A, ptd_pkg::DT_B8B: begin
                  pay_nxt = 4'd8;
                end
                ptd_pkg::DT_STR: begin
                  phase_nxt = ptd_pkg::PH_DAT_STR;
                end
                default: begin
                  res_gen    = 1'b1;
                  res_kind   = ptd_pkg::KIND_ERR;
                  res_err    = ptd_pkg::ERR_DATA;
                  halted_nxt = 1'b1;
                  phase_nxt  = ptd_pkg::PH_IDLE;
                end
              endcase
            end
          end
          ptd_pkg::PH_DAT_PAY: begin
            pay_nxt = pay_dec;
            if (pay_dec == 4'd0) begin
              phase_nxt = ptd_pkg::PH_IDLE;
            end
          end
          ptd_pkg::PH_DAT_STR: begin
            if (in_byte_value == 8'd0) begin
              phase_nxt = ptd_pkg::PH_IDLE;
            end
          end
          ptd_pkg::PH_REG_HDR: begin
            asm_nxt = shift_val;
            cnt_nxt = cnt_dec;
            if (cnt_dec == 4'd0) begin
              plvl_nxt  = shift_val[31:24];
              ptype_nxt = shift_val[23:16];
              pid_nxt   = {shift_val[13:8], shift_val[7:0]};
              phase_nxt = ptd_pkg::PH_REG_NAME;
            end
          end
          ptd_pkg::PH_REG_NAME: begin
            // level is committed on the name terminator
            if (in_byte_value == 8'd0) begin
              reg_wr    = (ptype_r == ptd_pkg::ID_TYPE_LEVEL) && pid_inrange;
              phase_nxt = ptd_pkg::PH_IDLE;
            end
          end
          default: begin
            phase_nxt = ptd_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ptd_pkg::PH_IDLE;
      cnt_r    <= '0;
      asm_r    <= '0;
      pid_r    <= '0;
      plvl_r   <= '0;
      ptype_r  <= '0;
      pay_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      asm_r    <= asm_nxt;
      pid_r    <= pid_nxt;
      plvl_r   <= plvl_nxt;
      ptype_r  <= ptype_nxt;
      pay_r    <= pay_nxt;
      halted_r <= halted_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Clearing pass: one table entry per cycle after reset
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == CLR_LAST) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Level table: one write port, one registered read port
  // ---------------------------------------------------------------------
  assign mem_we    = clr_active_r | reg_wr;
  assign mem_waddr = clr_active_r ? clr_cnt_r : pid_r[IDW-1:0];
  assign mem_wdata = clr_active_r ? 9'd0 : {1'b1, plvl_r};
  assign mem_re    = res_load & res_tp;
  assign mem_raddr = res_inrange ? res_id[IDW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_kind_r    <= res_kind;
      out_value_r   <= res_value;
      out_id_r      <= res_id;
      out_err_r     <= res_err;
      out_inrange_r <= res_tp & res_inrange;
    end
  end

  logic out_reg_hit;
  assign out_reg_hit = out_inrange_r & mem_q_r[8];

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_kind_r;
  assign out_event_value   = out_value_r;
  assign out_point_id      = out_id_r;
  assign out_error_code    = out_err_r;
  assign out_is_registered = out_reg_hit;
  assign out_point_level   = (out_kind_r != ptd_pkg::KIND_TP) ? 8'sd0 :
                             out_reg_hit ? $signed(mem_q_r[7:0]) : ptd_pkg::LEVEL_NONE;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // table port never gets a read and a write in one cycle
  a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("level table read and write collide");

  // every result completes an event, so the parser is idle afterwards
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (phase_r == ptd_pkg::PH_IDLE))
    else $error("parser not idle after a result");

  // an error result halts the block, and a halted block loads nothing
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && res_kind == ptd_pkg::KIND_ERR) |=> (halted_r && !res_load))
    else $error("block kept producing results after an error");

  // clearing pass ends only after its last entry
  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_active_r) |-> ($past(clr_cnt_r) == CLR_LAST))
    else $error("clearing pass ended early");

endmodule

// ===== tb/profiler_trace_event_decoder_tb.sv =====
// Self-checking testbench for the profiler trace event decoder.
`timescale 1ns / 1ps

module profiler_trace_event_decoder_tb;

  localparam int NUM_IDS        = 16384;
  localparam int RESET_CYCLES   = 9;
  localparam int ITEM_TARGET    = 1900;
  localparam int DRAIN_CYCLES   = 8;
  // Longest quiet stretch is the table clear after reset plus one gap and
  // one stall; allow a few times that.
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int MAX_REPORTS    = 10;

  // Timepoint encodings: 2, 4 and 8 bytes.
  typedef enum int {TP_SHORT, TP_MID, TP_LONG} tp_form_t;

  typedef struct packed {
    logic [7:0] value;
    logic       stream_end;
  } trace_byte_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [55:0] value;
    logic [13:0] id;
    logic [7:0]  level;
    logic        registered;
    logic [2:0]  err;
  } trace_event_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_byte_value = 8'h00;
  logic               in_stream_end = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_event_kind;
  logic [55:0]        out_event_value;
  logic [13:0]        out_point_id;
  logic signed [7:0]  out_point_level;
  logic               out_is_registered;
  logic [2:0]         out_error_code;

  profiler_trace_event_decoder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_value    (in_byte_value),
    .in_stream_end    (in_stream_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_event_value  (out_event_value),
    .out_point_id     (out_point_id),
    .out_point_level  (out_point_level),
    .out_is_registered(out_is_registered),
    .out_error_code   (out_error_code)
  );

  always #10 clk = ~clk;

  trace_byte_t  pending_bytes[$];    // bytes still to be sent
  trace_event_t expected_events[$];  // decoded events not yet seen on the output
  int           mismatches = 0;
  int           quiet_cycles = 0;

  // ---------------------------------------------------------------------
  // Decoder model state: level table, parser phase and assembly registers.
  // ---------------------------------------------------------------------
  logic [7:0]       tbl_level [NUM_IDS];
  bit               tbl_valid [NUM_IDS];
  ptd_pkg::phase_t  prs_phase = ptd_pkg::PH_IDLE;
  logic [3:0]       prs_count = '0;
  logic [55:0]      prs_asm = '0;
  logic [13:0]      prs_id = '0;
  logic [7:0]       prs_level = '0;
  logic [7:0]       prs_type = '0;
  logic [3:0]       prs_left = '0;
  bit               prs_halted = 1'b0;

  // Any error halts the parser; no further results until reset.
  function automatic bit raise_error(input logic [2:0] code, input logic [55:0] v,
                                     output trace_event_t ev);
    ev = '0;
    prs_halted = 1'b1;
    prs_phase = ptd_pkg::PH_IDLE;
    ev.kind = ptd_pkg::KIND_ERR;
    ev.value = v;
    ev.err = code;
    return 1'b1;
  endfunction

  // Timepoint result; the level comes from the table when the id is marked.
  function automatic bit make_timepoint(input logic [13:0] id, input logic [55:0] delta,
                                        output trace_event_t ev);
    ev = '0;
    prs_phase = ptd_pkg::PH_IDLE;
    ev.kind = ptd_pkg::KIND_TP;
    ev.value = delta;
    ev.id = id;
    if (tbl_valid[id]) begin
      ev.level = tbl_level[id];
      ev.registered = 1'b1;
    end else begin
      ev.level = ptd_pkg::LEVEL_NONE;
    end
    return 1'b1;
  endfunction

  // Advances the model by one accepted byte; returns 1 when it yields a result.
  function automatic bit decode_byte(input logic [7:0] b, input logic stream_end,
                                     output trace_event_t ev);
    ev = '0;
    if (prs_halted) return 1'b0;
    if (stream_end) begin
      case (prs_phase)
        ptd_pkg::PH_IDLE: begin
          ev.kind = ptd_pkg::KIND_END;
          return 1'b1;
        end
        ptd_pkg::PH_TP_SEC, ptd_pkg::PH_TP_THIRD, ptd_pkg::PH_TP_REST:
          return raise_error(ptd_pkg::ERR_TP_CUT, '0, ev);
        ptd_pkg::PH_HP: return raise_error(ptd_pkg::ERR_HP_CUT, '0, ev);
        ptd_pkg::PH_DAT_HDR, ptd_pkg::PH_DAT_PAY, ptd_pkg::PH_DAT_STR:
          return raise_error(ptd_pkg::ERR_DATA, '0, ev);
        default: return raise_error(ptd_pkg::ERR_REG_CUT, '0, ev);
      endcase
    end
    case (prs_phase)
      ptd_pkg::PH_IDLE: begin
        if (!b[7]) begin
          prs_asm = {48'd0, b};
          prs_phase = ptd_pkg::PH_TP_SEC;
        end else if (b[7:4] == ptd_pkg::LEAD_DATA_HI) begin
          prs_asm = {52'd0, b[3:0]};
          prs_count = 4'd2;
          prs_phase = ptd_pkg::PH_DAT_HDR;
        end else if (b == ptd_pkg::LEAD_HP) begin
          prs_asm = '0;
          prs_count = 4'd7;
          prs_phase = ptd_pkg::PH_HP;
        end else if (b == ptd_pkg::LEAD_REG) begin
          prs_asm = '0;
          prs_count = 4'd4;
          prs_phase = ptd_pkg::PH_REG_HDR;
        end else if (b != ptd_pkg::LEAD_PAD) begin
          return raise_error(ptd_pkg::ERR_UNKNOWN, {48'd0, b}, ev);
        end
      end
      ptd_pkg::PH_TP_SEC: begin
        if (!b[7]) return make_timepoint(prs_asm[13:0], {48'd0, b}, ev);
        prs_id = {prs_asm[6:0], b[6:0]};
        prs_phase = ptd_pkg::PH_TP_THIRD;
      end
      ptd_pkg::PH_TP_THIRD: begin
        if (!b[7]) begin
          prs_asm = {48'd0, b};
          prs_count = 4'd1;
        end else begin
          prs_asm = {49'd0, b[6:0]};
          prs_count = 4'd5;
        end
        prs_phase = ptd_pkg::PH_TP_REST;
      end
      ptd_pkg::PH_TP_REST: begin
        prs_asm = {prs_asm[47:0], b};
        prs_count = prs_count - 4'd1;
        if (prs_count == 4'd0) return make_timepoint(prs_id, prs_asm, ev);
      end
      ptd_pkg::PH_HP: begin
        prs_asm = {prs_asm[47:0], b};
        prs_count = prs_count - 4'd1;
        if (prs_count == 4'd0) begin
          prs_phase = ptd_pkg::PH_IDLE;
          ev.kind = ptd_pkg::KIND_HP;
          ev.value = prs_asm;
          return 1'b1;
        end
      end
      ptd_pkg::PH_DAT_HDR: begin
        prs_count = prs_count - 4'd1;
        if (prs_count != 4'd0) return 1'b0;
        case (prs_asm[3:0])
          ptd_pkg::DT_B1: prs_left = 4'd1;
          ptd_pkg::DT_B2: prs_left = 4'd2;
          ptd_pkg::DT_B4A, ptd_pkg::DT_B4B: prs_left = 4'd4;
          ptd_pkg::DT_B8A, ptd_pkg::DT_B8B: prs_left = 4'd8;
          ptd_pkg::DT_STR: begin
            prs_phase = ptd_pkg::PH_DAT_STR;
            return 1'b0;
          end
          default: return raise_error(ptd_pkg::ERR_DATA, '0, ev);
        endcase
        prs_phase = ptd_pkg::PH_DAT_PAY;
      end
      ptd_pkg::PH_DAT_PAY: begin
        prs_left = prs_left - 4'd1;
        if (prs_left == 4'd0) prs_phase = ptd_pkg::PH_IDLE;
      end
      ptd_pkg::PH_DAT_STR: begin
        if (b == 8'h00) prs_phase = ptd_pkg::PH_IDLE;
      end
      ptd_pkg::PH_REG_HDR: begin
        prs_asm = {prs_asm[47:0], b};
        prs_count = prs_count - 4'd1;
        if (prs_count == 4'd0) begin
          prs_level = prs_asm[31:24];
          prs_type = prs_asm[23:16];
          prs_id = prs_asm[13:0];
          prs_phase = ptd_pkg::PH_REG_NAME;
        end
      end
      ptd_pkg::PH_REG_NAME: begin
        // level lands in the table only on the name terminator
        if (b == 8'h00) begin
          if (prs_type == ptd_pkg::ID_TYPE_LEVEL) begin
            tbl_level[prs_id] = prs_level;
            tbl_valid[prs_id] = 1'b1;
          end
          prs_phase = ptd_pkg::PH_IDLE;
        end
      end
      default: prs_phase = ptd_pkg::PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Trace builders: each appends one event's bytes to the send queue.
  // ---------------------------------------------------------------------
  logic [13:0] id_pool [16];

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [13:0] pick_id();
    if ($urandom_range(0, 4) != 0) return id_pool[$urandom_range(0, 15)];
    return 14'($urandom);
  endfunction

  function automatic int draw_wait(input bit burst);
    if (burst) return 0;
    return $urandom_range(0, 16);
  endfunction

  task automatic push_byte(input logic [7:0] v);
    pending_bytes.push_back('{value: v, stream_end: 1'b0});
  endtask

  // the byte lane carries junk on an end marker; the block must ignore it
  task automatic push_end();
    pending_bytes.push_back('{value: 8'($urandom), stream_end: 1'b1});
  endtask

  task automatic gen_timepoint(input tp_form_t form, input logic [13:0] id,
                               input logic [46:0] delta);
    case (form)
      TP_SHORT: begin
        push_byte({1'b0, id[6:0]});
        push_byte({1'b0, delta[6:0]});
      end
      TP_MID: begin
        push_byte({1'b0, id[13:7]});
        push_byte({1'b1, id[6:0]});
        push_byte({1'b0, delta[14:8]});
        push_byte(delta[7:0]);
      end
      default: begin
        push_byte({1'b0, id[13:7]});
        push_byte({1'b1, id[6:0]});
        push_byte({1'b1, delta[46:40]});
        for (int i = 4; i >= 0; i--) push_byte(delta[i*8 +: 8]);
      end
    endcase
  endtask

  task automatic gen_stamp(input logic [55:0] ns);
    push_byte(ptd_pkg::LEAD_HP);
    for (int i = 6; i >= 0; i--) push_byte(ns[i*8 +: 8]);
  endtask

  // Top two bits of the id-high byte are don't-care and get random values.
  task automatic gen_register(input logic [7:0] level, input logic [7:0] id_type,
                              input logic [13:0] id, input int label_bytes);
    push_byte(ptd_pkg::LEAD_REG);
    push_byte(level);
    push_byte(id_type);
    push_byte({2'($urandom), id[13:8]});
    push_byte(id[7:0]);
    repeat (label_bytes) push_byte(8'($urandom_range(1, 255)));
    push_byte(8'h00);
  endtask

  // A bad type stops after the header; the block flags it there.
  task automatic gen_data(input logic [3:0] dtype);
    int n;
    n = 0;
    push_byte({ptd_pkg::LEAD_DATA_HI, dtype});
    push_byte(8'($urandom));
    push_byte(8'($urandom));
    case (dtype)
      ptd_pkg::DT_B1: n = 1;
      ptd_pkg::DT_B2: n = 2;
      ptd_pkg::DT_B4A, ptd_pkg::DT_B4B: n = 4;
      ptd_pkg::DT_B8A, ptd_pkg::DT_B8B: n = 8;
      ptd_pkg::DT_STR: begin
        repeat ($urandom_range(0, 6)) push_byte(8'($urandom_range(1, 255)));
        push_byte(8'h00);
      end
      default: n = 0;
    endcase
    repeat (n) push_byte(8'($urandom));
  endtask

  function automatic logic [3:0] pick_data_type();
    case ($urandom_range(0, 6))
      0: return ptd_pkg::DT_B1;
      1: return ptd_pkg::DT_B2;
      2: return ptd_pkg::DT_B4A;
      3: return ptd_pkg::DT_B8A;
      4: return ptd_pkg::DT_B4B;
      5: return ptd_pkg::DT_B8B;
      default: return ptd_pkg::DT_STR;
    endcase
  endfunction

  // Cuts the event that began at 'start' somewhere after its lead byte.
  task automatic truncate_from(input int start);
    int keep;
    keep = $urandom_range(1, pending_bytes.size() - start - 1);
    while (pending_bytes.size() > start + keep) void'(pending_bytes.pop_back());
  endtask

  // ---------------------------------------------------------------------
  // Input driver: one byte transfer per queue entry, random gaps between.
  // Predicts on every accepted transfer.
  // ---------------------------------------------------------------------
  int           gap_left = 0;
  bit           in_burst = 1'b0;
  trace_byte_t  next_byte;
  trace_event_t ev_pred;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_byte_value <= 8'h00;
      in_stream_end <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (decode_byte(in_byte_value, in_stream_end, ev_pred))
          expected_events.push_back(ev_pred);
      end
      // only move on once the current byte is gone; a stalled byte holds
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          next_byte = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_byte_value <= next_byte.value;
          in_stream_end <= next_byte.stream_end;
          gap_left = draw_wait(in_burst);
          if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: random stall per result, in-order compare.
  // ---------------------------------------------------------------------
  int           hold_left = 0;
  bit           out_burst = 1'b0;
  trace_event_t got;
  trace_event_t want;

  task automatic report_event(input string what, input trace_event_t e, input trace_event_t a);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $write("%0t %s: exp kind=%0d val=%h id=%h lvl=%h reg=%0b err=%0d | ",
             $time, what, e.kind, e.value, e.id, e.level, e.registered, e.err);
      $display("got kind=%0d val=%h id=%h lvl=%h reg=%0b err=%0d",
               a.kind, a.value, a.id, a.level, a.registered, a.err);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{kind: out_event_kind, value: out_event_value, id: out_point_id,
                level: out_point_level, registered: out_is_registered,
                err: out_error_code};
        if (expected_events.size() == 0) begin
          report_event("unexpected result", '0, got);
        end else begin
          want = expected_events.pop_front();
          if (got.kind !== want.kind || got.value !== want.value || got.id !== want.id ||
              got.level !== want.level || got.registered !== want.registered ||
              got.err !== want.err)
            report_event("result mismatch", want, got);
        end
        hold_left = draw_wait(out_burst);
        if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      end else if (out_valid && hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left > 0);
    end
  end

  // Watchdog: any transfer on either channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** profiler_trace_event_decoder: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: directed opener, random body, one error tail, then wind-down.
  // ---------------------------------------------------------------------
  initial begin
    int          r;
    int          start;
    logic [7:0]  lead;
    logic [3:0]  bad_type;
    logic [63:0] rv;

    id_pool[0] = 14'h0000;
    id_pool[1] = 14'h007F;
    id_pool[2] = 14'h3FFF;
    id_pool[3] = 14'h0080;
    // half the pool fits the short 7-bit id form
    for (int i = 4; i < 16; i++)
      id_pool[i] = (i < 10) ? 14'($urandom_range(0, 127)) : 14'($urandom);

    // Directed: clean end while idle, unregistered short timepoint,
    // registering the top id at the most negative level and reading it
    // back with the widest delta, stamp extreme, a mid timepoint, padding and a data event.
    push_end();
    gen_timepoint(TP_SHORT, 14'h007F, 47'h7F);
    gen_register(8'h80, ptd_pkg::ID_TYPE_LEVEL, 14'h3FFF, 0);
    gen_timepoint(TP_LONG, 14'h3FFF, '1);
    gen_stamp('1);
    gen_timepoint(TP_MID, 14'h0000, 47'h0);
    push_byte(ptd_pkg::LEAD_PAD);
    gen_data(ptd_pkg::DT_B1);

    // Random body: only whole events, so the parser never halts early.
    while (pending_bytes.size() < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        rv = rand64();
        if ($urandom_range(0, 9) == 0) rv = ($urandom_range(0, 1) != 0) ? '1 : '0;
        gen_timepoint(tp_form_t'($urandom_range(0, 2)), pick_id(), rv[46:0]);
      end else if (r < 55) begin
        gen_register(8'($urandom),
                     ($urandom_range(0, 4) != 0) ? ptd_pkg::ID_TYPE_LEVEL : 8'($urandom),
                     pick_id(),
                     ($urandom_range(0, 19) == 0) ? $urandom_range(4, 12)
                                                  : $urandom_range(0, 3));
      end else if (r < 65) begin
        gen_stamp(rand64());
      end else if (r < 80) begin
        gen_data(pick_data_type());
      end else if (r < 88) begin
        repeat ($urandom_range(1, 3)) push_byte(ptd_pkg::LEAD_PAD);
      end else begin
        push_end();
      end
    end

    // Error tail: only one error fits a run, so pick which at random.
    start = pending_bytes.size();
    case ($urandom_range(0, 5))
      0: begin
        gen_timepoint(tp_form_t'($urandom_range(0, 2)), pick_id(), 47'(rand64()));
        truncate_from(start);
        push_end();
      end
      1: begin
        gen_stamp(rand64());
        truncate_from(start);
        push_end();
      end
      2: begin
        gen_data(pick_data_type());
        truncate_from(start);
        push_end();
      end
      3: begin
        gen_register(8'($urandom), ptd_pkg::ID_TYPE_LEVEL, pick_id(), $urandom_range(0, 4));
        truncate_from(start);
        push_end();
      end
      4: begin
        // type zero and types seven to fourteen are not defined
        bad_type = 4'($urandom_range(6, 14));
        if (bad_type == 4'd6) bad_type = 4'd0;
        gen_data(bad_type);
      end
      default: begin
        do lead = 8'($urandom_range(8'h80, 8'hFC));
        while (lead[7:4] == ptd_pkg::LEAD_DATA_HI);
        push_byte(lead);
      end
    endcase
    // halted: everything after the error is swallowed silently
    repeat ($urandom_range(4, 12)) begin
      if ($urandom_range(0, 3) == 0) push_end();
      else push_byte(8'($urandom));
    end

    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_events.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", expected_events.size());
    end
    if (mismatches == 0) begin
      $display("** profiler_trace_event_decoder: PASSED **");
    end else begin
      $display("** profiler_trace_event_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ptd_pkg.sv
design/profiler_trace_event_decoder.sv
tb/profiler_trace_event_decoder_tb.sv
